@@ src/gbid_pkg.sv @@
package gbid_pkg;

  // Default bank width
  localparam int NUM_PINS_DEFAULT = 16;

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int OFF_W    = 4;
  localparam int DATA_W   = 16;
  localparam int PIN_W    = 4;
  localparam int CFG_IDX_W = 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_PIN   = 2'd2;

  // Register byte offsets
  localparam logic [OFF_W-1:0] OFF_DATA = 4'h0;
  localparam logic [OFF_W-1:0] OFF_DIR  = 4'h2;
  localparam logic [OFF_W-1:0] OFF_EN   = 4'h4;
  localparam logic [OFF_W-1:0] OFF_STAT = 4'h6;
  localparam logic [OFF_W-1:0] OFF_TYPE = 4'h8;

  // Byte lanes
  localparam logic [DATA_W-1:0] HIGH_LANE = 16'hFF00;
  localparam logic [DATA_W-1:0] LOW_LANE  = 16'h00FF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POL_LO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POL_HI = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic              byte_access;
    logic [OFF_W-1:0]  reg_offset;
    logic [DATA_W-1:0] write_data;
    logic [PIN_W-1:0]  pin_index;
    logic              pin_level;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              access_error;
    logic              irq_out;
  } res_t;

endpackage

@@ src/gbid_if.sv @@
interface gbid_in_if;
  import gbid_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic              byte_access;
  logic [OFF_W-1:0]  reg_offset;
  logic [DATA_W-1:0] write_data;
  logic [PIN_W-1:0]  pin_index;
  logic              pin_level;

  modport source (output valid, operation, byte_access, reg_offset, write_data,
                  pin_index, pin_level, input ready);
  modport sink   (input valid, operation, byte_access, reg_offset, write_data,
                  pin_index, pin_level, output ready);
endinterface

interface gbid_out_if;
  import gbid_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              access_error;
  logic              irq_out;

  modport source (output valid, read_data, access_error, irq_out, input ready);
  modport sink   (input valid, read_data, access_error, irq_out, output ready);
endinterface

@@ src/gbid_core.sv @@
module gbid_core #(
  parameter int NUM_PINS = gbid_pkg::NUM_PINS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_fire,
  input  gbid_pkg::item_t                item,
  input  logic                           cfg_we,
  input  logic [gbid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbid_pkg::DATA_W-1:0]    cfg_data,
  output gbid_pkg::res_t                 res
);
  import gbid_pkg::*;

  logic [DATA_W-1:0]   pol_lo_r, pol_hi_r;
  logic [NUM_PINS-1:0] lev_r, dir_r, en_r, stat_r, type_r;
  logic [NUM_PINS-1:0] lev_nxt, dir_nxt, en_nxt, stat_nxt, type_nxt;

  logic [DATA_W-1:0]   rd_val, wr_val, wr_keep;
  logic                rd_ok, wr_ok;
  logic [NUM_PINS-1:0] pin_bit;
  logic [DATA_W-1:0]   pol;
  logic                pin_ok, prev, pin_en, pin_edge, pol_rise, pol_both, fired;

  // Bus read decode
  always_comb begin
    rd_ok  = 1'b1;
    rd_val = '0;
    case (item.reg_offset)
      OFF_DATA: rd_val = DATA_W'(lev_r & ~dir_r);
      OFF_DIR:  rd_val = DATA_W'(dir_r);
      OFF_EN:   rd_val = DATA_W'(en_r);
      OFF_STAT: rd_val = DATA_W'(stat_r);
      OFF_TYPE: rd_val = DATA_W'(type_r);
      default:  rd_ok  = 1'b0;
    endcase
  end

  // Write lanes: a byte write leaves the high lane alone
  assign wr_val  = item.byte_access ? (item.write_data & LOW_LANE) : item.write_data;
  assign wr_keep = item.byte_access ? HIGH_LANE : '0;

  // Pin event terms
  assign pin_ok   = {1'b0, item.pin_index} < (PIN_W+1)'(NUM_PINS);
  assign pin_bit  = NUM_PINS'(DATA_W'(1) << item.pin_index);
  assign prev     = |(lev_r & pin_bit);
  assign pin_en   = |(en_r & pin_bit);
  assign pin_edge = |(type_r & pin_bit);
  assign pol      = item.pin_index[PIN_W-1] ? pol_hi_r : pol_lo_r;
  assign pol_rise = pol[{1'b0, item.pin_index[2:0]}];
  assign pol_both = pol[{1'b1, item.pin_index[2:0]}];

  always_comb begin
    if (pol_both) begin
      fired = prev != item.pin_level;
    end else if (pol_rise) begin
      fired = !prev && item.pin_level;
    end else begin
      fired = prev && !item.pin_level;
    end
  end

  // Next state and result
  always_comb begin
    lev_nxt  = lev_r;
    dir_nxt  = dir_r;
    en_nxt   = en_r;
    stat_nxt = stat_r;
    type_nxt = type_r;
    wr_ok    = 1'b1;
    res      = '0;
    case (item.operation)
      OP_READ: begin
        if (rd_ok) begin
          res.read_data = item.byte_access ? (rd_val & LOW_LANE) : rd_val;
        end else begin
          res.access_error = 1'b1;
        end
      end
      OP_WRITE: begin
        case (item.reg_offset)
          OFF_DIR:  dir_nxt  = NUM_PINS'((DATA_W'(dir_r) & wr_keep) | wr_val);
          OFF_EN:   en_nxt   = NUM_PINS'((DATA_W'(en_r) & wr_keep) | wr_val);
          OFF_TYPE: type_nxt = NUM_PINS'((DATA_W'(type_r) & wr_keep) | wr_val);
          OFF_STAT: stat_nxt = stat_r & ~NUM_PINS'(wr_val);
          default:  wr_ok    = 1'b0;
        endcase
        res.access_error = !wr_ok;
      end
      OP_PIN: begin
        if (pin_ok) begin
          lev_nxt = item.pin_level ? (lev_r | pin_bit) : (lev_r & ~pin_bit);
          if (pin_en) begin
            if (pin_edge) begin
              if (fired) stat_nxt = stat_r | pin_bit;
            end else if (item.pin_level == pol_rise) begin
              stat_nxt = stat_r | pin_bit;
            end else begin
              stat_nxt = stat_r & ~pin_bit;
            end
          end
        end
      end
      default: ;
    endcase
    res.irq_out = |(stat_nxt & en_nxt);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lev_r  <= '0;
      dir_r  <= '0;
      en_r   <= '0;
      stat_r <= '0;
      type_r <= '0;
    end else if (in_fire) begin
      lev_r  <= lev_nxt;
      dir_r  <= dir_nxt;
      en_r   <= en_nxt;
      stat_r <= stat_nxt;
      type_r <= type_nxt;
    end
  end

  // Polarity configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_lo_r <= '0;
      pol_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POL_LO: pol_lo_r <= cfg_data;
        CFG_POL_HI: pol_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // An errored access returns no data
  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res.access_error |-> res.read_data == '0)
    else $error("errored access returned data");

  // A read leaves every bank register (level, direction, enable, status, type) as it was
  a_read_stable: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && item.operation == OP_READ |=>
      $stable(lev_r) && $stable(dir_r) && $stable(en_r) && $stable(stat_r)
      && $stable(type_r))
    else $error("read changed state");

  // A pin event only touches the bit of its own pin
  a_pin_local: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && item.operation == OP_PIN |->
      ((lev_nxt ^ lev_r) & ~pin_bit) == '0 && ((stat_nxt ^ stat_r) & ~pin_bit) == '0)
    else $error("pin event touched another pin");

endmodule

@@ src/gbid_skid.sv @@
module gbid_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  gbid_pkg::res_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output gbid_pkg::res_t out_data
);
  import gbid_pkg::*;

  logic out_vld_r, skid_vld_r;
  res_t out_r, skid_r;
  logic push, load;

  assign in_ready  = !skid_vld_r;
  assign push      = in_valid && in_ready;
  // Output register is free when empty or its result is being taken
  assign load      = !out_vld_r || out_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r  <= skid_vld_r || push;
      skid_vld_r <= 1'b0;
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= skid_vld_r ? skid_r : in_data;
    end else if (push) begin
      skid_r <= in_data;
    end
  end

  // Skid only fills behind a held output
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid full with output empty");

  // Skid entry moves to the output once the output is taken
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && out_ready |=> out_vld_r && !skid_vld_r && out_r == $past(skid_r))
    else $error("skid entry lost");

  // A transfer into a free output appears there next cycle
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    push && load && !skid_vld_r |=> out_vld_r && out_r == $past(in_data))
    else $error("result not loaded");

endmodule

@@ src/gpio_bank_interrupt_detect.sv @@
// Channel  Dir  Fields                                                      Handshake
// in_ch    in   operation byte_access reg_offset write_data pin_index level valid/ready
// out_ch   out  read_data access_error irq_out                              valid/ready
// cfg_*    in   cfg_index cfg_data (polarity words 0 and 1)                 cfg_we, no wait
//
// One item per clock while in_ch.ready is high: the register file, pin detection and
// result register (or skid, while the output is held) all load at the input transfer.
// A two-entry output stage (register plus skid) keeps in_ch.ready high while
// one result waits; in_ch.ready drops only when both entries are full.
// rst_n is synchronous, active low, and clears all registers and polarity words.
module gpio_bank_interrupt_detect #(
  parameter int NUM_PINS = gbid_pkg::NUM_PINS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gbid_in_if.sink                        in_ch,
  gbid_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [gbid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbid_pkg::DATA_W-1:0]    cfg_data
);
  import gbid_pkg::*;

  item_t item;
  res_t  core_res, out_res;
  logic  in_rdy, in_fire;

  // Gather the input transfer
  assign item.operation   = in_ch.operation;
  assign item.byte_access = in_ch.byte_access;
  assign item.reg_offset  = in_ch.reg_offset;
  assign item.write_data  = in_ch.write_data;
  assign item.pin_index   = in_ch.pin_index;
  assign item.pin_level   = in_ch.pin_level;

  assign in_ch.ready = in_rdy;
  assign in_fire     = in_ch.valid && in_rdy;

  gbid_core #(.NUM_PINS(NUM_PINS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (core_res)
  );

  gbid_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_rdy),
    .in_data   (core_res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_res)
  );

  assign out_ch.read_data    = out_res.read_data;
  assign out_ch.access_error = out_res.access_error;
  assign out_ch.irq_out      = out_res.irq_out;

endmodule
